FILE: rtl/bgfsl_pkg.sv
//------------------------------------------------------------------------------
// bgfsl_pkg
// Shared types and constants of the block-grouped free slot list.
//------------------------------------------------------------------------------
`default_nettype none

package bgfsl_pkg;

    localparam int BLOCK_COUNT_DEF    = 256;
    localparam int MAX_SPB_DEF        = 64;
    localparam int SPB_W              = 7;
    localparam int CMD_W              = 2;
    localparam int SLOT_W             = 14;
    localparam int TOTAL_W            = 15;
    localparam int NBLK_W             = 9;
    localparam int STATUS_W           = 2;

    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TAKE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SORT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SLOT_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   taken_slot;
        logic [TOTAL_W-1:0]  free_slots_total;
        logic [NBLK_W-1:0]   blocks_with_free;
    } rsp_t;

    // Controller to datapath commands
    typedef enum logic [3:0] {
        OP_NONE,
        OP_DIV_START,
        OP_ADD_RD,
        OP_ADD_WR,
        OP_TAKE_RD,
        OP_TAKE_SLOT,
        OP_TAKE_WR,
        OP_SORT_INIT,
        OP_SORT_RD,
        OP_SORT_WR,
        OP_LOAD_RSP
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  rsp_status;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic add_ok;
        logic take_ok;
        logic sort_empty;
        logic sort_done;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/bgfsl_datapath.sv
//------------------------------------------------------------------------------
// bgfsl_datapath
// Divider, block tables, slot store and order registers.
//------------------------------------------------------------------------------
`default_nettype none

module bgfsl_datapath #(
    parameter int BLOCK_COUNT = bgfsl_pkg::BLOCK_COUNT_DEF,
    parameter int MAX_SPB     = bgfsl_pkg::MAX_SPB_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire logic [bgfsl_pkg::SPB_W-1:0]   spb_cfg,
    input  wire bgfsl_pkg::req_t               req,
    input  wire bgfsl_pkg::dp_cmd_t            cmd,
    output bgfsl_pkg::dp_stat_t                stat,
    output bgfsl_pkg::rsp_t                    rsp
);
    import bgfsl_pkg::*;

    localparam int BLK_W  = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int POS_W  = (MAX_SPB > 1) ? $clog2(MAX_SPB) : 1;
    localparam int CNT_W  = $clog2(MAX_SPB + 1);
    localparam int QW     = SLOT_W;
    localparam int DEPTH  = BLOCK_COUNT * (1 << POS_W);
    localparam int SCW    = $clog2(MAX_SPB + 1);
    localparam int BCW    = $clog2(BLOCK_COUNT + 1);
    localparam int SUM_W  = POS_W + 1;

    // Memories
    logic [CNT_W-1:0]  cnt_mem  [BLOCK_COUNT];
    logic [POS_W-1:0]  head_mem [BLOCK_COUNT];
    logic [BLK_W-1:0]  next_mem [BLOCK_COUNT];
    logic [SLOT_W-1:0] slot_mem [DEPTH];
    logic [BLOCK_COUNT-1:0] valid_reg;

    // Effective divisor
    logic [CNT_W-1:0] spb_eff;
    always_comb
    begin
        if (spb_cfg == '0)
            spb_eff = CNT_W'(1);
        else if (32'(spb_cfg) > MAX_SPB)
            spb_eff = CNT_W'(MAX_SPB);
        else
            spb_eff = CNT_W'(spb_cfg);
    end

    // Restoring divider, one quotient bit per cycle
    logic [QW-1:0]    quo_reg;
    logic [CNT_W:0]   rem_reg;
    logic [4:0]       dcnt_reg;
    logic             dbusy_reg;
    logic [CNT_W:0]   rem_sh;
    assign rem_sh = {rem_reg[CNT_W-1:0], quo_reg[QW-1]};

    // Order state
    logic [BLK_W-1:0]  ohead_reg, otail_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [NBLK_W-1:0]  nblk_reg;

    // Read stage
    logic [CNT_W-1:0]  c_reg;
    logic [POS_W-1:0]  h_reg;
    logic [BLK_W-1:0]  nx_reg;
    logic [SLOT_W-1:0] sd_reg;
    logic [SLOT_W-1:0] taken_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic              blk_oob_reg;

    // Sort sweep
    logic [SCW-1:0] sc_reg;
    logic [BCW-1:0] sb_reg;

    logic [QW-1:0] q_hi;
    assign q_hi = quo_reg >> BLK_W;

    logic [BLK_W-1:0] rd_blk;
    always_comb
    begin
        case (cmd.op)
            OP_TAKE_RD:   rd_blk = ohead_reg;
            OP_TAKE_SLOT: rd_blk = ohead_reg;
            OP_SORT_RD:   rd_blk = sb_reg[BLK_W-1:0];
            default:      rd_blk = blk_reg;
        endcase
    end

    // Ring positions wrap by compare and subtract
    logic [SUM_W-1:0] wr_sum;
    logic [POS_W-1:0] wr_pos;
    logic [POS_W-1:0] hd_nxt;
    always_comb
    begin
        wr_sum = SUM_W'(h_reg) + SUM_W'(c_reg);
        if (32'(wr_sum) >= MAX_SPB)
            wr_pos = POS_W'(32'(wr_sum) - MAX_SPB);
        else
            wr_pos = POS_W'(wr_sum);
        if (32'(h_reg) >= MAX_SPB - 1)
            hd_nxt = '0;
        else
            hd_nxt = h_reg + POS_W'(1);
    end

    always_ff @(posedge clk)
    begin
        c_reg  <= valid_reg[rd_blk] ? cnt_mem[rd_blk] : '0;
        h_reg  <= valid_reg[rd_blk] ? head_mem[rd_blk] : '0;
        nx_reg <= next_mem[ohead_reg];
        sd_reg <= slot_mem[{ohead_reg, h_reg}];
        if (cmd.op == OP_ADD_WR)
        begin
            cnt_mem[blk_reg]  <= c_reg + CNT_W'(1);
            head_mem[blk_reg] <= h_reg;
            slot_mem[{blk_reg, wr_pos}] <= req.slot_index;
            if (c_reg == '0 && nblk_reg != '0)
                next_mem[otail_reg] <= blk_reg;
        end
        else if (cmd.op == OP_TAKE_WR)
        begin
            cnt_mem[ohead_reg]  <= c_reg - CNT_W'(1);
            head_mem[ohead_reg] <= hd_nxt;
        end
        else if (cmd.op == OP_SORT_WR)
        begin
            if (c_reg == CNT_W'(sc_reg) && nblk_reg != '0)
                next_mem[otail_reg] <= sb_reg[BLK_W-1:0];
        end
        if (dbusy_reg && dcnt_reg == '0)
        begin
            blk_reg     <= q_hi == '0 ? quo_reg[BLK_W-1:0] : '0;
            blk_oob_reg <= q_hi != '0 || 32'(quo_reg) >= BLOCK_COUNT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            ohead_reg <= '0;
            otail_reg <= '0;
            total_reg <= '0;
            nblk_reg  <= '0;
            sc_reg    <= '0;
            sb_reg    <= '0;
            taken_reg <= '0;
            rsp       <= '0;
        end
        else
        begin
            if (cmd.op == OP_DIV_START)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= 5'(QW);
                quo_reg   <= req.slot_index;
                rem_reg   <= '0;
            end
            else if (dbusy_reg && dcnt_reg != '0)
            begin
                dcnt_reg <= dcnt_reg - 5'd1;
                if (rem_sh >= {1'b0, spb_eff})
                begin
                    rem_reg <= rem_sh - {1'b0, spb_eff};
                    quo_reg <= {quo_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[QW-2:0], 1'b0};
                end
            end
            else
                dbusy_reg <= 1'b0;

            case (cmd.op)
                OP_ADD_WR:
                begin
                    valid_reg[blk_reg] <= 1'b1;
                    total_reg <= total_reg + TOTAL_W'(1);
                    if (c_reg == '0)
                    begin
                        if (nblk_reg == '0)
                            ohead_reg <= blk_reg;
                        otail_reg <= blk_reg;
                        nblk_reg  <= nblk_reg + NBLK_W'(1);
                    end
                end
                OP_TAKE_WR:
                begin
                    valid_reg[ohead_reg] <= 1'b1;
                    total_reg <= total_reg - TOTAL_W'(1);
                    taken_reg <= sd_reg;
                    if (c_reg == CNT_W'(1))
                    begin
                        nblk_reg <= nblk_reg - NBLK_W'(1);
                        if (nblk_reg != NBLK_W'(1))
                            ohead_reg <= nx_reg;
                    end
                end
                OP_SORT_INIT:
                begin
                    nblk_reg <= '0;
                    sc_reg   <= SCW'(MAX_SPB);
                    sb_reg   <= '0;
                end
                OP_SORT_WR:
                begin
                    if (c_reg == CNT_W'(sc_reg))
                    begin
                        if (nblk_reg == '0)
                            ohead_reg <= sb_reg[BLK_W-1:0];
                        otail_reg <= sb_reg[BLK_W-1:0];
                        nblk_reg  <= nblk_reg + NBLK_W'(1);
                    end
                    if (32'(sb_reg) == BLOCK_COUNT - 1)
                    begin
                        sb_reg <= '0;
                        sc_reg <= sc_reg - SCW'(1);
                    end
                    else
                        sb_reg <= sb_reg + BCW'(1);
                end
                OP_LOAD_RSP:
                begin
                    rsp.status           <= cmd.rsp_status;
                    rsp.taken_slot       <= (cmd.rsp_status == ST_OK) ? taken_reg : '0;
                    rsp.free_slots_total <= total_reg;
                    rsp.blocks_with_free <= nblk_reg;
                    taken_reg            <= '0;
                end
                default: ;
            endcase
        end
    end

    assign stat.div_done   = dbusy_reg && dcnt_reg == '0;
    assign stat.add_ok     = !blk_oob_reg && c_reg < spb_eff;
    assign stat.take_ok    = total_reg != '0 && nblk_reg != '0;
    assign stat.sort_empty = nblk_reg == '0;
    assign stat.sort_done  = sc_reg == SCW'(1) && 32'(sb_reg) == BLOCK_COUNT - 1;

    // Total never exceeds store size
    assert property (@(posedge clk) disable iff (!rst_n) 32'(total_reg) <= DEPTH)
        else $error("free total overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_TAKE_WR |-> c_reg != '0)
        else $error("take from empty block");
    assert property (@(posedge clk) disable iff (!rst_n)
        nblk_reg == '0 |-> (total_reg == '0 || cmd.op == OP_SORT_WR
                            || $past(cmd.op) == OP_SORT_INIT || cmd.op == OP_SORT_RD))
        else $error("slots held with no block in order");

endmodule

`default_nettype wire

FILE: rtl/bgfsl_ctrl.sv
//------------------------------------------------------------------------------
// bgfsl_ctrl
// Sequencer for add, take and sort requests.
//------------------------------------------------------------------------------
`default_nettype none

module bgfsl_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  wire bgfsl_pkg::req_t    req,
    input  wire bgfsl_pkg::dp_stat_t stat,
    output bgfsl_pkg::dp_cmd_t      cmd,
    output logic                    out_valid,
    input  wire                     out_stall,
    output logic                    cfg_ready
);
    import bgfsl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_ADD_RD, S_ADD_CHK, S_TAKE_RD, S_TAKE_SLOT, S_TAKE_WR,
        S_SORT_RD, S_SORT_WR, S_RSP, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_next;
    logic [1:0] st_reg, st_next;
    logic   busy_reg;

    assign in_stall  = state_reg != S_IDLE;
    assign cfg_ready = state_reg == S_IDLE && !out_valid;

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        out_valid_next = out_valid && out_stall;
        cmd.op         = OP_NONE;
        cmd.rsp_status = st_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    st_next = ST_OK;
                    case (req.command)
                        CMD_ADD:  begin cmd.op = OP_DIV_START; state_next = S_DIV; end
                        CMD_TAKE: state_next = S_TAKE_RD;
                        CMD_SORT: state_next = S_SORT_RD;
                        default:  state_next = S_RSP;
                    endcase
                end
            S_DIV:
                if (stat.div_done) state_next = S_ADD_RD;
            S_ADD_RD:
            begin
                cmd.op = OP_ADD_RD;
                state_next = S_ADD_CHK;
            end
            S_ADD_CHK:
            begin
                if (stat.add_ok) cmd.op = OP_ADD_WR;
                else st_next = ST_REJECTED;
                state_next = S_RSP;
            end
            S_TAKE_RD:
                if (!stat.take_ok)
                begin
                    st_next = ST_EMPTY;
                    state_next = S_RSP;
                end
                else
                begin
                    cmd.op = OP_TAKE_RD;
                    state_next = S_TAKE_SLOT;
                end
            S_TAKE_SLOT:
            begin
                cmd.op = OP_TAKE_SLOT;
                state_next = S_TAKE_WR;
            end
            S_TAKE_WR:
            begin
                cmd.op = OP_TAKE_WR;
                state_next = S_RSP;
            end
            S_SORT_RD:
                if (busy_reg)
                begin
                    cmd.op = OP_SORT_RD;
                    state_next = S_SORT_WR;
                end
                else if (stat.sort_empty)
                    state_next = S_RSP;
                else
                    cmd.op = OP_SORT_INIT;
            S_SORT_WR:
            begin
                cmd.op = OP_SORT_WR;
                state_next = stat.sort_done ? S_RSP : S_SORT_RD;
            end
            S_RSP:
                if (!out_valid || !out_stall)
                begin
                    cmd.op = OP_LOAD_RSP;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
            out_valid <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            out_valid <= out_valid_next;
            if (cmd.op == OP_SORT_INIT) busy_reg <= 1'b1;
            else if (state_next == S_RSP) busy_reg <= 1'b0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_LOAD_RSP |=> out_valid)
        else $error("response not presented");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != S_IDLE)
        else $error("accepted request dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> state_reg == S_IDLE)
        else $error("config taken while busy");

endmodule

`default_nettype wire

FILE: rtl/block_grouped_free_slot_list.sv
//------------------------------------------------------------------------------
// block_grouped_free_slot_list
// Free list of slot indices grouped by page block, with block reordering.
//------------------------------------------------------------------------------
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | bgfsl_pkg::req_t
// out     | out | out_valid/out_stall| bgfsl_pkg::rsp_t
// cfg     | in  | cfg_valid/cfg_ready| slots_per_block, 7 bits
//
// Add: the restoring divider, then lookup and update.
// Take: read tables, read slot, update, load; an empty list goes straight to the load.
// Sort: table sweep over every block per slot count; unknown code: straight to load.
// Reset clears control state; the block tables use per-block valid bits.
// A held response stalls only the next response load, not the next request.
//------------------------------------------------------------------------------
`default_nettype none

module block_grouped_free_slot_list #(
    parameter int BLOCK_COUNT         = bgfsl_pkg::BLOCK_COUNT_DEF,
    parameter int MAX_SLOTS_PER_BLOCK = bgfsl_pkg::MAX_SPB_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire bgfsl_pkg::req_t              in_data,
    output logic                              out_valid,
    input  wire                               out_stall,
    output bgfsl_pkg::rsp_t                   out_data,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [bgfsl_pkg::SPB_W-1:0]  cfg_data
);
    import bgfsl_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    req_t     req_reg;
    logic [SPB_W-1:0] spb_reg;

    // Hold the request for the whole sequence
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            req_reg <= in_data;
    end

    // Hold the divisor register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            spb_reg <= SPB_W'(64);
        else if (cfg_valid && cfg_ready)
            spb_reg <= cfg_data;
    end

    bgfsl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req       (in_data),
        .stat      (stat),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_ready (cfg_ready)
    );

    bgfsl_datapath #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .MAX_SPB     (MAX_SLOTS_PER_BLOCK)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .spb_cfg (spb_reg),
        .req     (cmd.op == OP_DIV_START ? in_data : req_reg),
        .cmd     (cmd),
        .stat    (stat),
        .rsp     (out_data)
    );

endmodule

`default_nettype wire
